// ----- hdl/skin_bulge_correction_assert.svh -----
// assertion helpers shared by the sqrt, pull and top files
// both expect i_clk and i_rst_n in the enclosing module
`ifndef SKIN_BULGE_CORRECTION_ASSERT_SVH
`define SKIN_BULGE_CORRECTION_ASSERT_SVH

// same-cycle implication
`define SBC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sbc assertion failed");

// next-cycle implication
`define SBC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sbc assertion failed");

`endif

// ----- hdl/sbc_pkg.sv -----
// ----------------------------------------------------------------------------
// sbc_pkg
// shared constants of the skin bulge correction pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package sbc_pkg;
    localparam int NUM_AXES = 3;
    typedef logic [NUM_AXES-1:0] t_axis_mask;
endpackage

`default_nettype wire

// ----- hdl/sbc_div.sv -----
// ----------------------------------------------------------------------------
// sbc_div
// pipelined restoring divider, one quotient bit per stage: rest*2^(2F)/curr
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_div #(
    parameter int CW = 32,
    parameter int F  = 16,
    parameter int SW = 8
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire logic [CW-1:0]   i_rest,
    input  wire logic [CW-1:0]   i_curr,
    input  wire logic [SW-1:0]   i_side,
    output logic                 o_valid,
    output logic [2*F-1:0]       o_quo,
    output logic [SW-1:0]        o_side
);
    localparam int N = 2 * F;

    logic            r_valid [N];
    logic [CW-1:0]   r_rem   [N];
    logic [CW-1:0]   r_curr  [N];
    logic [N-1:0]    r_quo   [N];
    logic [SW-1:0]   r_side  [N];

    logic [CW-1:0]   n_rem   [N];
    logic [N-1:0]    n_quo   [N];

    always_comb begin
        logic [CW-1:0] rem_in;
        logic [CW-1:0] curr_in;
        logic [N-1:0]  quo_in;
        logic [CW:0]   rem2;
        logic [CW:0]   diff;
        logic          ge;
        for (int i = 0; i < N; i++) begin
            if (i == 0) begin
                rem_in  = i_rest;
                curr_in = i_curr;
                quo_in  = '0;
            end else begin
                rem_in  = r_rem[i-1];
                curr_in = r_curr[i-1];
                quo_in  = r_quo[i-1];
            end
            rem2     = {rem_in, 1'b0};
            ge       = rem2 >= {1'b0, curr_in};
            diff     = rem2 - {1'b0, curr_in};
            n_rem[i] = ge ? diff[CW-1:0] : rem2[CW-1:0];
            n_quo[i] = {quo_in[N-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) r_valid[i] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int i = 1; i < N; i++) r_valid[i] <= r_valid[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < N; i++) begin
                r_rem[i] <= n_rem[i];
                r_quo[i] <= n_quo[i];
                if (i == 0) begin
                    r_curr[i] <= i_curr;
                    r_side[i] <= i_side;
                end else begin
                    r_curr[i] <= r_curr[i-1];
                    r_side[i] <= r_side[i-1];
                end
            end
        end
    end

    assign o_valid = r_valid[N-1];
    assign o_quo   = r_quo[N-1];
    assign o_side  = r_side[N-1];

endmodule

`default_nettype wire

// ----- hdl/sbc_sqrt.sv -----
// ----------------------------------------------------------------------------
// sbc_sqrt
// pipelined digit-by-digit integer square root, one root bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_sqrt #(
    parameter int F  = 16,
    parameter int SW = 8
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire logic [2*F-1:0]  i_rad,
    input  wire logic [SW-1:0]   i_side,
    output logic                 o_valid,
    output logic [F-1:0]         o_root,
    output logic [SW-1:0]        o_side
);
    logic            r_valid [F];
    logic [2*F-1:0]  r_rad   [F];
    logic [F+1:0]    r_rem   [F];
    logic [F-1:0]    r_root  [F];
    logic [SW-1:0]   r_side  [F];

    logic [2*F-1:0]  n_rad   [F];
    logic [F+1:0]    n_rem   [F];
    logic [F-1:0]    n_root  [F];

    always_comb begin
        logic [2*F-1:0] rad_in;
        logic [F+1:0]   rem_in;
        logic [F-1:0]   root_in;
        logic [F+3:0]   temp;
        logic [F+3:0]   trial;
        logic [F+3:0]   diff;
        logic           ge;
        for (int i = 0; i < F; i++) begin
            if (i == 0) begin
                rad_in  = i_rad;
                rem_in  = '0;
                root_in = '0;
            end else begin
                rad_in  = r_rad[i-1];
                rem_in  = r_rem[i-1];
                root_in = r_root[i-1];
            end
            // bring down the next two radicand bits
            temp      = {rem_in, rad_in[2*F-1 -: 2]};
            trial     = {2'b00, root_in, 2'b01};
            ge        = temp >= trial;
            diff      = temp - trial;
            n_rem[i]  = ge ? diff[F+1:0] : temp[F+1:0];
            n_root[i] = {root_in[F-2:0], ge};
            n_rad[i]  = {rad_in[2*F-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < F; i++) r_valid[i] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int i = 1; i < F; i++) r_valid[i] <= r_valid[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < F; i++) begin
                r_rad[i]  <= n_rad[i];
                r_rem[i]  <= n_rem[i];
                r_root[i] <= n_root[i];
                if (i == 0) r_side[i] <= i_side;
                else        r_side[i] <= r_side[i-1];
            end
        end
    end

    assign o_valid = r_valid[F-1];
    assign o_root  = r_root[F-1];
    assign o_side  = r_side[F-1];

    `include "skin_bulge_correction_assert.svh"

    // remainder of a floor square root never exceeds twice the root
    `SBC_ASSERT_IMP(a_sqrt_rem, r_valid[F-1], r_rem[F-1] <= {1'b0, r_root[F-1], 1'b0})

endmodule

`default_nettype wire

// ----- hdl/sbc_pull.sv -----
// ----------------------------------------------------------------------------
// sbc_pull
// per-axis pull toward the projection if corr is set, else vert: proj + f*(vert-proj), saturated
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_pull #(
    parameter int CW = 32,
    parameter int F  = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_en,
    input  wire logic                                   i_valid,
    input  wire logic [F-1:0]                           i_f,
    input  wire logic                                   i_corr,
    input  wire logic [sbc_pkg::NUM_AXES-1:0][CW-1:0]   i_vert,
    input  wire logic [sbc_pkg::NUM_AXES-1:0][CW-1:0]   i_proj,
    output logic                                        o_valid,
    output logic [sbc_pkg::NUM_AXES-1:0][CW-1:0]        o_out,
    output logic                                        o_corr
);
    import sbc_pkg::*;

    localparam int PW = F + CW + 1;

    // stage 1: difference magnitude and sign
    logic                             r_v1, r_v2, r_v3;
    logic [F-1:0]                     r1_f;
    logic                             r1_corr, r2_corr, r3_corr;
    logic [NUM_AXES-1:0][CW:0]        r1_mag, r2_mag;
    t_axis_mask                       r1_neg, r2_neg;
    logic [NUM_AXES-1:0][CW-1:0]      r1_vert, r1_proj, r2_vert, r2_proj, r3_out;
    logic [NUM_AXES-1:0][PW-1:0]      r2_prod;

    logic [NUM_AXES-1:0][CW:0]        n1_mag;
    t_axis_mask                       n1_neg;
    logic [NUM_AXES-1:0][CW-1:0]      n3_out;

    always_comb begin
        logic [CW:0] d;
        for (int a = 0; a < NUM_AXES; a++) begin
            d         = {i_vert[a][CW-1], i_vert[a]} - {i_proj[a][CW-1], i_proj[a]};
            n1_neg[a] = d[CW];
            n1_mag[a] = d[CW] ? (~d + 1'b1) : d;
        end
    end

    always_comb begin
        logic [CW:0]   sm;
        logic [CW+1:0] off;
        logic [CW+1:0] sum;
        for (int a = 0; a < NUM_AXES; a++) begin
            sm  = r2_prod[a][PW-1:F];
            off = r2_neg[a] ? (~{1'b0, sm} + 1'b1) : {1'b0, sm};
            sum = {{2{r2_proj[a][CW-1]}}, r2_proj[a]} + off;
            if (!r2_corr) begin
                n3_out[a] = r2_vert[a];
            end else if (sum[CW+1:CW-1] == 3'b000 || sum[CW+1:CW-1] == 3'b111) begin
                n3_out[a] = sum[CW-1:0];
            end else if (sum[CW+1]) begin
                n3_out[a] = {1'b1, {(CW-1){1'b0}}};
            end else begin
                n3_out[a] = {1'b0, {(CW-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_f    <= i_f;
            r1_corr <= i_corr;
            r1_mag  <= n1_mag;
            r1_neg  <= n1_neg;
            r1_vert <= i_vert;
            r1_proj <= i_proj;
            for (int a = 0; a < NUM_AXES; a++) begin
                r2_prod[a] <= {{(CW+1){1'b0}}, r1_f} * {{F{1'b0}}, r1_mag[a]};
            end
            r2_mag  <= r1_mag;
            r2_neg  <= r1_neg;
            r2_vert <= r1_vert;
            r2_proj <= r1_proj;
            r2_corr <= r1_corr;
            r3_out  <= n3_out;
            r3_corr <= r2_corr;
        end
    end

    assign o_valid = r_v3;
    assign o_out   = r3_out;
    assign o_corr  = r3_corr;

    `include "skin_bulge_correction_assert.svh"

    // scaled offset never exceeds the original offset since f is below one
    `SBC_ASSERT_IMP(a_pull_shrinks, r_v2, r2_prod[0][PW-1:F] <= r2_mag[0])

endmodule

`default_nettype wire

// ----- hdl/skin_bulge_correction.sv -----
// ----------------------------------------------------------------------------
// skin_bulge_correction
// streaming bulge correction of skinned vertices toward their bone projection
// ----------------------------------------------------------------------------
// input channel: i_valid / o_stall carries one vertex request: position,
// projection on the bone segment and the rest and current squared distances.
// output channel: o_valid / i_stall returns the corrected position and a
// flag telling whether the pull was applied.
// a request moves when valid is high and stall is low at a clock edge.
// a request passes in order through the restoring divider, one quotient
// bit per stage, the square root, one root bit per stage, and the
// difference, multiply and saturating add stages; every stage is a pipeline
// register. throughput is one vertex per cycle while no result is held.
// when the receiver stalls with a result waiting, the whole pipeline holds
// and o_stall is raised toward the sender; nothing is dropped or repeated.
// synchronous reset clears all valid bits, so the pipeline comes up empty.
// ----------------------------------------------------------------------------
`default_nettype none

module skin_bulge_correction #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic [COORD_WIDTH-1:0] i_vert_x,
    input  wire logic [COORD_WIDTH-1:0] i_vert_y,
    input  wire logic [COORD_WIDTH-1:0] i_vert_z,
    input  wire logic [COORD_WIDTH-1:0] i_proj_x,
    input  wire logic [COORD_WIDTH-1:0] i_proj_y,
    input  wire logic [COORD_WIDTH-1:0] i_proj_z,
    input  wire logic [COORD_WIDTH-1:0] i_rest_dist_sq,
    input  wire logic [COORD_WIDTH-1:0] i_curr_dist_sq,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic [COORD_WIDTH-1:0]      o_out_x,
    output logic [COORD_WIDTH-1:0]      o_out_y,
    output logic [COORD_WIDTH-1:0]      o_out_z,
    output logic                        o_corrected
);
    import sbc_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int SW = 1 + 2 * NUM_AXES * CW;

    logic                         w_en;
    logic [SW-1:0]                w_side_in, w_side_div, w_side_sqrt;
    logic                         w_div_valid, w_sqrt_valid;
    logic [2*F-1:0]               w_quo;
    logic [F-1:0]                 w_root;
    logic [NUM_AXES-1:0][CW-1:0]  w_vert, w_proj, w_out;

    // whole pipeline advances unless a finished result is held back
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    assign w_side_in = {(i_rest_dist_sq < i_curr_dist_sq),
                        i_vert_z, i_vert_y, i_vert_x,
                        i_proj_z, i_proj_y, i_proj_x};

    sbc_div #(.CW(CW), .F(F), .SW(SW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_rest  (i_rest_dist_sq),
        .i_curr  (i_curr_dist_sq),
        .i_side  (w_side_in),
        .o_valid (w_div_valid),
        .o_quo   (w_quo),
        .o_side  (w_side_div)
    );

    sbc_sqrt #(.F(F), .SW(SW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_div_valid),
        .i_rad   (w_quo),
        .i_side  (w_side_div),
        .o_valid (w_sqrt_valid),
        .o_root  (w_root),
        .o_side  (w_side_sqrt)
    );

    assign w_proj = w_side_sqrt[NUM_AXES*CW-1:0];
    assign w_vert = w_side_sqrt[2*NUM_AXES*CW-1:NUM_AXES*CW];

    sbc_pull #(.CW(CW), .F(F)) u_pull (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sqrt_valid),
        .i_f     (w_root),
        .i_corr  (w_side_sqrt[SW-1]),
        .i_vert  (w_vert),
        .i_proj  (w_proj),
        .o_valid (o_valid),
        .o_out   (w_out),
        .o_corr  (o_corrected)
    );

    assign o_out_x = w_out[0];
    assign o_out_y = w_out[1];
    assign o_out_z = w_out[2];

    `include "skin_bulge_correction_assert.svh"

    // a held result stays present while the pipeline is frozen
    `SBC_ASSERT_NXT(a_hold_valid, o_valid && i_stall, o_valid)
    // backpressure toward the sender only ever comes from a waiting result
    `SBC_ASSERT_IMP(a_stall_cause, o_stall, o_valid && i_stall)

endmodule

`default_nettype wire
